// ===== rtl/assert_macros.svh =====
// Assertion macros used by the lexer top level.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Check that a condition always holds outside reset.
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`endif

// ===== rtl/lex_pkg.sv =====
// Types and constants for the C subset lexer.
// No dependencies.
package lex_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic        is_text;
        logic [7:0]  text_byte;
        logic [5:0]  token_kind;
        logic [31:0] int_value;
        logic [15:0] token_line;
        logic [15:0] token_column;
        logic        last_of_item;
    } t_out_item;

    typedef enum logic [4:0] {
        M_IDLE, M_SLASH, M_LINE, M_BLOCK, M_BLOCK_STAR, M_IDENT, M_NUMBER,
        M_STRING, M_STRING_ESC, M_CHAR_OPEN, M_CHAR_ESC, M_CHAR_CLOSE, M_OP_FIRST
    } t_lex_mode;

    localparam logic [5:0] K_END    = 6'd0;
    localparam logic [5:0] K_IDENT  = 6'd15;
    localparam logic [5:0] K_INT    = 6'd16;
    localparam logic [5:0] K_STRING = 6'd17;
    localparam logic [5:0] K_CHAR   = 6'd18;
    localparam logic [5:0] K_SLASH  = 6'd30;

    // Byte class found by the front end.
    typedef enum logic [2:0] {
        C_OTHER, C_SPACE, C_ALPHA, C_DIGIT, C_NEWLINE
    } t_byte_class;

    // Classified item passed from front to back.
    typedef struct packed {
        logic [7:0]  in_byte;
        logic        eoi;
        t_byte_class cls;
        logic [15:0] line;
        logic [15:0] column;
    } t_cls_item;

    function automatic logic [5:0] single_kind(input logic [7:0] b);
        logic [5:0] k;
        begin
            unique case (b)
                8'h2b: k = 6'd27;  8'h2d: k = 6'd28;  8'h2a: k = 6'd29;
                8'h2f: k = 6'd30;  8'h25: k = 6'd31;  8'h26: k = 6'd32;
                8'h7c: k = 6'd33;  8'h5e: k = 6'd34;  8'h7e: k = 6'd35;
                8'h28: k = 6'd36;  8'h29: k = 6'd37;  8'h7b: k = 6'd38;
                8'h7d: k = 6'd39;  8'h5b: k = 6'd40;  8'h5d: k = 6'd41;
                8'h3b: k = 6'd42;  8'h2c: k = 6'd43;  8'h3d: k = 6'd44;
                8'h3c: k = 6'd45;  8'h3e: k = 6'd46;
                default: k = K_END;
            endcase
            return k;
        end
    endfunction

    function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
        logic [5:0] k;
        begin
            k = K_END;
            if (a == "&" && b == "&") k = 6'd19;
            if (a == "|" && b == "|") k = 6'd20;
            if (a == "=" && b == "=") k = 6'd21;
            if (a == "!" && b == "=") k = 6'd22;
            if (a == "<" && b == "=") k = 6'd23;
            if (a == ">" && b == "=") k = 6'd24;
            if (a == "<" && b == "<") k = 6'd25;
            if (a == ">" && b == ">") k = 6'd26;
            return k;
        end
    endfunction

    function automatic logic [7:0] escape_of(input logic [7:0] b);
        logic [7:0] r;
        begin
            r = b;
            if (b == "n") r = 8'h0a;
            if (b == "t") r = 8'h09;
            return r;
        end
    endfunction

endpackage

// ===== rtl/lex_front.sv =====
// Front end: accepts bytes, classifies them and tracks source position.
// Depends on lex_pkg.
module lex_front import lex_pkg::*; #(
    parameter int POSITION_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_in_item  i_item,
    output logic      o_full,
    output logic      o_valid,
    output t_cls_item o_item,
    input  logic      i_take
);
    localparam logic [POSITION_WIDTH-1:0] PosMax = '1;

    logic [POSITION_WIDTH-1:0] r_line, r_col, n_line, n_col;
    logic      r_valid;
    t_cls_item r_item, n_item;
    logic      accept;
    logic [7:0] b;

    assign o_full  = r_valid && !i_take;
    assign accept  = i_push && !o_full;
    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign b       = i_item.in_byte;

    always_comb begin
        n_line = r_line;
        n_col  = r_col;
        if (!i_item.end_of_input) begin
            if (b == 8'h0a) begin
                if (r_line != PosMax) n_line = r_line + 1'b1;
                n_col = POSITION_WIDTH'(1);
            end else if (r_col != PosMax) begin
                n_col = r_col + 1'b1;
            end
        end
        n_item.in_byte = b;
        n_item.eoi     = i_item.end_of_input;
        if (b == 8'h0a) n_item.cls = C_NEWLINE;
        else if (b == 8'h20 || (b >= 8'd9 && b <= 8'd13)) n_item.cls = C_SPACE;
        else if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_")
            n_item.cls = C_ALPHA;
        else if (b >= "0" && b <= "9") n_item.cls = C_DIGIT;
        else n_item.cls = C_OTHER;
        n_item.line   = 16'(r_line);
        n_item.column = 16'(r_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_line  <= POSITION_WIDTH'(1);
            r_col   <= POSITION_WIDTH'(1);
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
                r_line  <= n_line;
                r_col   <= n_col;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_item <= n_item;
    end
endmodule

// ===== rtl/lex_back.sv =====
// Back end: token state machine and result queue.
// Depends on lex_pkg.
module lex_back import lex_pkg::*; #(
    parameter int KEYWORD_MAX_LEN = 8,
    parameter int VALUE_WIDTH     = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_cls_item i_item,
    output logic      o_take,
    output logic      o_empty,
    output t_out_item o_item,
    input  logic      i_pop
);
    localparam int QDepth = 8;
    localparam int QAw    = 3;
    localparam int LenW   = $clog2(KEYWORD_MAX_LEN + 2);

    t_lex_mode r_mode, n_mode;
    logic [7:0] r_kw [KEYWORD_MAX_LEN];
    logic [LenW-1:0] r_len, n_len;
    logic [VALUE_WIDTH-1:0] r_acc, n_acc;
    logic [7:0] r_held, n_held;
    logic [15:0] r_sl, r_sc, n_sl, n_sc;

    t_out_item r_q [QDepth];
    logic [QAw-1:0] r_wp, r_rp;
    logic [QAw:0] r_cnt;

    t_out_item res [3];
    logic [1:0] nres;
    logic kw_wr;
    logic [5:0] kw_kind;
    logic [7:0] b;
    logic [VALUE_WIDTH-1:0] acc_next;

    assign b = i_item.in_byte;
    assign o_take  = i_valid && (r_cnt <= (QAw+1)'(QDepth - 3));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_q[r_rp];
    assign acc_next = VALUE_WIDTH'(r_acc * VALUE_WIDTH'(10))
                      + VALUE_WIDTH'(b - "0");

    function automatic logic kw_eq(input logic [7:0] kw [KEYWORD_MAX_LEN],
                                   input logic [LenW-1:0] len, input logic [63:0] s,
                                   input int n);
        logic ok;
        begin
            ok = (len == LenW'(n));
            for (int i = 0; i < 8; i++)
                if (i < n && i < KEYWORD_MAX_LEN)
                    if (kw[i] != s[8*(n-1-i) +: 8]) ok = 1'b0;
            return ok;
        end
    endfunction

    always_comb begin
        kw_kind = K_IDENT;
        if      (kw_eq(r_kw, r_len, 64'("int"), 3))      kw_kind = 6'd1;
        else if (kw_eq(r_kw, r_len, 64'("char"), 4))     kw_kind = 6'd2;
        else if (kw_eq(r_kw, r_len, 64'("float"), 5))    kw_kind = 6'd3;
        else if (kw_eq(r_kw, r_len, 64'("void"), 4))     kw_kind = 6'd4;
        else if (kw_eq(r_kw, r_len, 64'("enum"), 4))     kw_kind = 6'd5;
        else if (kw_eq(r_kw, r_len, 64'("union"), 5))    kw_kind = 6'd6;
        else if (kw_eq(r_kw, r_len, 64'("if"), 2))       kw_kind = 6'd7;
        else if (kw_eq(r_kw, r_len, 64'("else"), 4))     kw_kind = 6'd8;
        else if (kw_eq(r_kw, r_len, 64'("for"), 3))      kw_kind = 6'd9;
        else if (kw_eq(r_kw, r_len, 64'("while"), 5))    kw_kind = 6'd10;
        else if (kw_eq(r_kw, r_len, 64'("do"), 2))       kw_kind = 6'd11;
        else if (kw_eq(r_kw, r_len, 64'("return"), 6))   kw_kind = 6'd12;
        else if (kw_eq(r_kw, r_len, 64'("break"), 5))    kw_kind = 6'd13;
        else if (kw_eq(r_kw, r_len, 64'("continue"), 8)) kw_kind = 6'd14;
    end

    // Results are collected in order into res[0..nres-1].
    always_comb begin
        t_out_item tk;
        logic      idle_go;
        logic [15:0] ssl, ssc;
        n_mode = r_mode; n_len = r_len; n_acc = r_acc; n_held = r_held;
        n_sl = r_sl; n_sc = r_sc; kw_wr = 1'b0; nres = '0; idle_go = 1'b0;
        ssl = i_item.line; ssc = i_item.column;
        for (int i = 0; i < 3; i++) res[i] = '0;
        tk = '0;
        tk.token_line = r_sl; tk.token_column = r_sc;
        if (i_item.eoi) begin
            unique case (r_mode)
                M_SLASH:      begin tk.token_kind = K_SLASH; res[0] = tk; nres = 2'd1; end
                M_IDENT:      begin tk.token_kind = kw_kind; res[0] = tk; nres = 2'd1; end
                M_NUMBER:     begin
                    tk.token_kind = K_INT; tk.int_value = 32'(r_acc);
                    res[0] = tk; nres = 2'd1;
                end
                M_STRING_ESC: begin
                    res[0] = tk; res[0].is_text = 1'b1; res[0].text_byte = 8'h5c;
                    tk.token_kind = K_STRING; res[1] = tk; nres = 2'd2;
                end
                M_STRING:     begin tk.token_kind = K_STRING; res[0] = tk; nres = 2'd1; end
                M_CHAR_OPEN, M_CHAR_ESC: begin
                    tk.token_kind = K_CHAR; res[0] = tk; nres = 2'd1;
                end
                M_OP_FIRST:   begin
                    tk.token_kind = single_kind(r_held); res[0] = tk; nres = 2'd1;
                end
                default: ;
            endcase
            res[nres] = '0;
            res[nres].token_kind = K_END;
            res[nres].token_line = i_item.line;
            res[nres].token_column = i_item.column;
            nres = nres + 2'd1;
            n_mode = M_IDLE;
        end else begin
            unique case (r_mode)
                M_SLASH: begin
                    if (b == "/") n_mode = M_LINE;
                    else if (b == "*") n_mode = M_BLOCK;
                    else begin
                        tk.token_kind = K_SLASH; res[0] = tk; nres = 2'd1; idle_go = 1'b1;
                    end
                end
                M_LINE:  if (i_item.cls == C_NEWLINE) n_mode = M_IDLE;
                M_BLOCK: if (b == "*") n_mode = M_BLOCK_STAR;
                M_BLOCK_STAR: begin
                    if (b == "/") n_mode = M_IDLE;
                    else if (b != "*") n_mode = M_BLOCK;
                end
                M_IDENT: begin
                    if (i_item.cls == C_ALPHA || i_item.cls == C_DIGIT) begin
                        res[0] = tk; res[0].is_text = 1'b1; res[0].text_byte = b;
                        nres = 2'd1;
                        if (r_len < LenW'(KEYWORD_MAX_LEN)) begin
                            kw_wr = 1'b1; n_len = r_len + 1'b1;
                        end else n_len = LenW'(KEYWORD_MAX_LEN + 1);
                    end else begin
                        tk.token_kind = kw_kind; res[0] = tk; nres = 2'd1; idle_go = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (i_item.cls == C_DIGIT) n_acc = acc_next;
                    else begin
                        tk.token_kind = K_INT; tk.int_value = 32'(r_acc);
                        res[0] = tk; nres = 2'd1; idle_go = 1'b1;
                    end
                end
                M_STRING: begin
                    if (b == 8'h22) begin
                        tk.token_kind = K_STRING; res[0] = tk; nres = 2'd1; n_mode = M_IDLE;
                    end else if (b == 8'h5c) n_mode = M_STRING_ESC;
                    else begin
                        res[0] = tk; res[0].is_text = 1'b1; res[0].text_byte = b;
                        nres = 2'd1;
                    end
                end
                M_STRING_ESC: begin
                    res[0] = tk; res[0].is_text = 1'b1; res[0].text_byte = escape_of(b);
                    nres = 2'd1; n_mode = M_STRING;
                end
                M_CHAR_OPEN: begin
                    if (b == 8'h5c) n_mode = M_CHAR_ESC;
                    else begin
                        tk.token_kind = K_CHAR; tk.int_value = 32'(b);
                        res[0] = tk; nres = 2'd1; n_mode = M_CHAR_CLOSE;
                    end
                end
                M_CHAR_ESC: begin
                    tk.token_kind = K_CHAR; tk.int_value = 32'(escape_of(b));
                    res[0] = tk; nres = 2'd1; n_mode = M_CHAR_CLOSE;
                end
                M_CHAR_CLOSE: begin
                    if (b == 8'h27) n_mode = M_IDLE;
                    else idle_go = 1'b1;
                end
                M_OP_FIRST: begin
                    if (pair_kind(r_held, b) != K_END) begin
                        tk.token_kind = pair_kind(r_held, b);
                        res[0] = tk; nres = 2'd1; n_mode = M_IDLE;
                    end else begin
                        tk.token_kind = single_kind(r_held);
                        res[0] = tk; nres = 2'd1; idle_go = 1'b1;
                    end
                end
                default: idle_go = 1'b1;
            endcase
            if (idle_go) begin
                n_mode = M_IDLE;
                if (i_item.cls != C_SPACE && i_item.cls != C_NEWLINE) begin
                    n_sl = i_item.line; n_sc = i_item.column;
                    if (b == "/") n_mode = M_SLASH;
                    else if (i_item.cls == C_ALPHA) begin
                        n_mode = M_IDENT; n_len = LenW'(1); kw_wr = 1'b1;
                        res[nres] = '0; res[nres].is_text = 1'b1; res[nres].text_byte = b;
                        res[nres].token_line = ssl; res[nres].token_column = ssc;
                        nres = nres + 2'd1;
                    end else if (i_item.cls == C_DIGIT) begin
                        n_mode = M_NUMBER; n_acc = VALUE_WIDTH'(b - "0");
                    end else if (b == 8'h22) n_mode = M_STRING;
                    else if (b == 8'h27) n_mode = M_CHAR_OPEN;
                    else if (b == "&" || b == "|" || b == "=" || b == "!" ||
                             b == "<" || b == ">") begin
                        n_mode = M_OP_FIRST; n_held = b;
                    end else begin
                        res[nres] = '0; res[nres].token_kind = single_kind(b);
                        res[nres].token_line = ssl; res[nres].token_column = ssc;
                        nres = nres + 2'd1;
                    end
                end
            end
        end
        if (nres != '0) res[nres - 2'd1].last_of_item = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_len <= '0; r_acc <= '0; r_held <= '0;
            r_sl <= 16'd1; r_sc <= 16'd1;
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (o_take) begin
                r_mode <= n_mode; r_len <= n_len; r_acc <= n_acc; r_held <= n_held;
                r_sl <= n_sl; r_sc <= n_sc;
                r_wp <= r_wp + QAw'(nres);
            end
            if (i_pop && !o_empty) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (o_take ? (QAw+1)'(nres) : '0)
                     - ((QAw+1)'(i_pop && !o_empty));
        end
    end

    // Keyword buffer and result queue storage.
    always_ff @(posedge i_clk) begin
        if (o_take && kw_wr) begin
            if (n_len == LenW'(1) && n_mode == M_IDENT && r_mode != M_IDENT)
                r_kw[0] <= b;
            else if (n_len == LenW'(1)) r_kw[0] <= b;
            else r_kw[r_len[LenW-1:0] >= LenW'(KEYWORD_MAX_LEN) ? '0 :
                      $clog2(KEYWORD_MAX_LEN)'(r_len)] <= b;
        end
        if (o_take) begin
            for (int i = 0; i < 3; i++)
                if (2'(i) < nres) r_q[r_wp + QAw'(i)] <= res[i];
        end
    end
endmodule

// ===== rtl/c_subset_lexer_step_unit.sv =====
// Top level of the C subset lexer: front classifier plus token back end.
// Depends on lex_pkg, lex_front, lex_back and assert_macros.svh.
//
// Usage:
//   Input channel: drive i_item (source byte and end-of-input flag) and
//   raise push; a transaction completes on a clock edge with push high
//   and full low. Output channel: while empty is low the oldest result
//   sits on o_item; a transaction completes when pop is high and empty low.
//   Each input byte gives zero to three results; the last one carries
//   last_of_item. Identifier and string text bytes come out before their
//   token.
//   Path: the front register captures the input transaction, then the back
//   end writes the result queue when it takes the classified byte; the
//   result can then be popped.
//   Throughput: one byte per cycle while the result queue has room, set by the
//   token state machine; an eight-entry result queue absorbs bursts.
//   Stall: when the receiver holds off, the queue fills, the back end stops
//   taking classified bytes once fewer than three slots are free and full
//   rises; nothing is dropped.
//   Reset (synchronous, i_rst_n low): mode idle, line and column one,
//   queue empty.
`include "assert_macros.svh"
module c_subset_lexer_step_unit import lex_pkg::*; #(
    parameter int KEYWORD_MAX_LEN = 8,
    parameter int POSITION_WIDTH  = 16,
    parameter int VALUE_WIDTH     = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item
);
    logic      f_valid, b_take;
    t_cls_item f_item;

    // Front: accept and classify bytes, advance position.
    lex_front #(.POSITION_WIDTH(POSITION_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .i_item, .o_full(full),
        .o_valid(f_valid), .o_item(f_item), .i_take(b_take)
    );

    // Back: run the token state machine and hold results.
    lex_back #(.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .i_clk, .i_rst_n, .i_valid(f_valid), .i_item(f_item), .o_take(b_take),
        .o_empty(empty), .o_item, .i_pop(pop)
    );

    `CHK_IMPL(a_take_valid, i_clk, i_rst_n, b_take, f_valid, "take without item")
    `CHK_IMPL(a_text_no_kind, i_clk, i_rst_n, !empty && o_item.is_text,
              o_item.token_kind == K_END, "text result carries kind")
    `CHK_ALWAYS(a_kind_range, i_clk, i_rst_n, empty || o_item.token_kind <= 6'd46,
                "kind out of range")
endmodule
